// ----- rtl/core/fcb_pkg.sv -----
// Shared types, constants and CRC-8 helpers for the framed header builder.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package fcb_pkg;

  // Header layout
  localparam logic [3:0] HdrLast = 4'd9;
  localparam logic [3:0] CrcSlot = 4'd4;
  localparam logic [7:0] Sync0   = 8'hAA;
  localparam logic [7:0] Sync1   = 8'h55;
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [4:0] HdrSize = 5'd10;

  // Request codes
  localparam logic ReqOpen = 1'b0;
  localparam logic ReqData = 1'b1;

  // Result status codes
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusReject = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 17;
  localparam logic [CfgAddrW-1:0] CfgBufferCapacity = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgMaxFrameType   = 1'b1;

  localparam logic [16:0] CapacityReset = 17'd1034;
  localparam logic [7:0]  MaxTypeReset  = 8'd3;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic        req_type;
    logic [15:0] payload_length;
    logic [7:0]  frame_type;
    logic [31:0] timestamp;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] header_index;
    logic [7:0] header_byte;
    logic       status;
    logic       last;
  } out_item_t;

  // One unit of work for the back end: a reject or a full header run
  typedef struct packed {
    logic        reject;
    logic [15:0] length;
    logic [7:0]  ftype;
    logic [31:0] timestamp;
    logic [7:0]  crc;
  } job_t;

  // One MSB-first CRC-8 bit step
  function automatic logic [7:0] crc8_bit(logic [7:0] crc, logic d);
    logic fb;
    fb = crc[7] ^ d;
    return {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
  endfunction

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      c = crc8_bit(c, b[k]);
    end
    return c;
  endfunction

  // Header CRC over sync, length, type and timestamp. The CRC is linear, so
  // the result is a constant for the sync bytes followed by zeros, XOR one
  // constant column for every set field bit.
  function automatic logic [7:0] hdr_crc(logic [15:0] len, logic [7:0] ftype,
                                         logic [31:0] ts);
    logic [55:0] msg;
    logic [7:0]  base;
    logic [7:0]  col;
    logic [7:0]  acc;
    msg  = {len, ftype, ts};
    base = crc8_byte(crc8_byte(8'h00, Sync0), Sync1);
    for (int k = 0; k < 56; k++) begin
      base = crc8_bit(base, 1'b0);
    end
    acc = base;
    col = CrcPoly;
    for (int i = 0; i < 56; i++) begin
      if (msg[i]) begin
        acc = acc ^ col;
      end
      col = crc8_bit(col, 1'b0);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fcb_front.sv -----
// Front end: takes requests, checks opens against the config registers,
// keeps the running CRC and bytes left, and queues finished jobs. Uses fcb_pkg.
`default_nettype none

module fcb_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fcb_pkg::in_item_t             in_data,
  input  wire logic                          cfg_we,
  input  wire logic [fcb_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [fcb_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire logic                          q_full,
  output logic                               q_push,
  output fcb_pkg::job_t                      q_job
);

  logic [16:0] capacity_r;
  logic [7:0]  max_type_r;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] left_r, left_nxt;
  logic        open_r, open_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] ts_r, ts_nxt;

  logic        accept;
  logic        bad_open;
  logic [17:0] need;
  logic [7:0]  open_crc;
  logic [7:0]  data_crc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign need     = {2'b00, in_data.payload_length} + 18'(fcb_pkg::HdrSize);
  assign bad_open = (in_data.frame_type > max_type_r) || (need > {1'b0, capacity_r});
  assign open_crc = fcb_pkg::hdr_crc(in_data.payload_length, in_data.frame_type,
                                     in_data.timestamp);
  assign data_crc = fcb_pkg::crc8_byte(crc_r, in_data.data_byte);

  always_comb begin
    crc_nxt  = crc_r;
    left_nxt = left_r;
    open_nxt = open_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    ts_nxt   = ts_r;
    q_push   = 1'b0;
    q_job    = '{reject: 1'b0, length: len_r, ftype: type_r, timestamp: ts_r,
                 crc: data_crc};
    if (accept) begin
      if (in_data.req_type == fcb_pkg::ReqOpen) begin
        if (bad_open) begin
          // drop any open frame and report the reject
          open_nxt     = 1'b0;
          left_nxt     = '0;
          q_push       = 1'b1;
          q_job.reject = 1'b1;
        end else begin
          len_nxt  = in_data.payload_length;
          type_nxt = in_data.frame_type;
          ts_nxt   = in_data.timestamp;
          crc_nxt  = open_crc;
          left_nxt = in_data.payload_length;
          open_nxt = (in_data.payload_length != 16'd0);
          if (in_data.payload_length == 16'd0) begin
            q_push = 1'b1;
            q_job  = '{reject: 1'b0, length: in_data.payload_length,
                       ftype: in_data.frame_type, timestamp: in_data.timestamp,
                       crc: open_crc};
          end
        end
      end else if (open_r) begin
        crc_nxt  = data_crc;
        left_nxt = left_r - 16'd1;
        if (left_r == 16'd1) begin
          open_nxt = 1'b0;
          q_push   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= fcb_pkg::CapacityReset;
      max_type_r <= fcb_pkg::MaxTypeReset;
      crc_r      <= '0;
      left_r     <= '0;
      open_r     <= 1'b0;
      len_r      <= '0;
      type_r     <= '0;
      ts_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          fcb_pkg::CfgBufferCapacity: capacity_r <= cfg_wdata;
          fcb_pkg::CfgMaxFrameType:   max_type_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      crc_r  <= crc_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
      len_r  <= len_nxt;
      type_r <= type_nxt;
      ts_r   <= ts_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fcb_queue.sv -----
// Short job queue between front and back ends.
// Uses fcb_pkg for the job type and depth.
`default_nettype none

module fcb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fcb_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output fcb_pkg::job_t      pop_job
);

  fcb_pkg::job_t                    slot_r [fcb_pkg::QueueDepth];
  logic [fcb_pkg::QueuePtrW-1:0]    wr_r, wr_nxt;
  logic [fcb_pkg::QueuePtrW-1:0]    rd_r, rd_nxt;
  logic [fcb_pkg::QueueCntW-1:0]    cnt_r, cnt_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (cnt_r == fcb_pkg::QueueCntW'(fcb_pkg::QueueDepth));
  assign valid   = (cnt_r != '0);
  assign pop_job = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == fcb_pkg::QueuePtrW'(fcb_pkg::QueueDepth - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == fcb_pkg::QueuePtrW'(fcb_pkg::QueueDepth - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fcb_back.sv -----
// Back end: turns queued jobs into result bytes through an output register.
// Uses fcb_pkg for the job and result types.
`default_nettype none

module fcb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire fcb_pkg::job_t q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fcb_pkg::out_item_t out_data
);

  fcb_pkg::job_t      job_r, job_nxt;
  logic               busy_r, busy_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  fcb_pkg::out_item_t out_r, out_nxt;

  logic       adv;
  logic       emit;
  logic       last_now;
  logic [7:0] hbyte;

  assign adv      = !out_valid_r || out_ready;
  assign emit     = busy_r && adv;
  assign last_now = job_r.reject || (idx_r == fcb_pkg::HdrLast);
  assign q_pop    = q_valid && (!busy_r || (emit && last_now));

  always_comb begin
    unique case (idx_r)
      4'd0:             hbyte = fcb_pkg::Sync0;
      4'd1:             hbyte = fcb_pkg::Sync1;
      4'd2:             hbyte = job_r.length[15:8];
      4'd3:             hbyte = job_r.length[7:0];
      fcb_pkg::CrcSlot: hbyte = job_r.crc;
      4'd5:             hbyte = job_r.ftype;
      4'd6:             hbyte = job_r.timestamp[31:24];
      4'd7:             hbyte = job_r.timestamp[23:16];
      4'd8:             hbyte = job_r.timestamp[15:8];
      4'd9:             hbyte = job_r.timestamp[7:0];
      default:          hbyte = 8'h00;
    endcase
  end

  always_comb begin
    job_nxt       = q_pop ? q_job : job_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (job_r.reject) begin
        out_nxt = '{header_index: 4'd0, header_byte: 8'h00,
                    status: fcb_pkg::StatusReject, last: 1'b1};
      end else begin
        out_nxt = '{header_index: idx_r, header_byte: hbyte,
                    status: fcb_pkg::StatusOk, last: last_now};
      end
      idx_nxt = idx_r + 4'd1;
      if (last_now) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/framed_header_crc8_builder.sv -----
// Top level of the framed header builder: front end, job queue, back end.
// Depends on fcb_pkg, fcb_front, fcb_queue and fcb_back.
`default_nettype none

// An open request (req_type 0) is checked and, if good, seeds a CRC-8
// (poly 0x07, init 0, MSB first) over the nine non-CRC header bytes; each
// payload request (req_type 1) then folds one byte in, one request per cycle
// while the job queue is not full. After the last payload byte, or on the
// open itself for length zero, ten header results (index 0..9, CRC at
// index 4) follow on consecutive cycles when the output is ready; a bad open
// gives one result with status 1. The output side runs at one result per
// cycle while the output is ready; a two-entry job queue lets new requests
// keep flowing in while a header run is sent, and the input stalls only when
// both queue entries are waiting. With the back end idle, a job that completes
// a frame passes the queue slot, the job register and the output register.
module framed_header_crc8_builder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fcb_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fcb_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [fcb_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [fcb_pkg::CfgDataW-1:0]  cfg_wdata
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  fcb_pkg::job_t push_job;
  fcb_pkg::job_t pop_job;

  fcb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  fcb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  fcb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A reject is always a single closing result at index zero
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == fcb_pkg::StatusReject) |->
      out_data.last && (out_data.header_index == 4'd0))
    else $error("reject result not a lone last result");

  // Header runs start with the sync bytes
  a_sync_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == fcb_pkg::StatusOk) &&
      ((out_data.header_index == 4'd0 && out_data.header_byte != fcb_pkg::Sync0) ||
       (out_data.header_index == 4'd1 && out_data.header_byte != fcb_pkg::Sync1)) |-> 1'b0)
    else $error("sync byte wrong");

  // Within a run the next byte follows at once with the next index
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && (out_data.header_index == 4'($past(out_data.header_index) + 4'd1)))
    else $error("header run broken");

  // Last flag marks exactly the final header byte
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == fcb_pkg::StatusOk) |->
      (out_data.last == (out_data.header_index == fcb_pkg::HdrLast)))
    else $error("last flag on wrong header byte");

endmodule

`default_nettype wire

// ----- sim/framed_header_crc8_builder_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for framed_header_crc8_builder: directed and random requests,
// with header bytes and CRC predicted from the request stream. Depends on fcb_pkg.

class header_tracker;
  localparam int HeaderLen = 10;
  localparam int CrcPos = 4;
  localparam logic [7:0] SyncHi = 8'hAA;
  localparam logic [7:0] SyncLo = 8'h55;
  localparam logic [7:0] Poly = 8'h07;

  logic [16:0] capacity;
  logic [7:0]  max_type;
  logic [7:0]  crc;
  logic [15:0] left;
  bit          open;
  logic [15:0] len_h;
  logic [7:0]  type_h;
  logic [31:0] ts_h;
  fcb_pkg::out_item_t expected_bytes[$];
  int unsigned mismatches;

  function new();
    capacity = 17'd1034;
    max_type = 8'd3;
    crc = 8'h00;
    left = 16'h0000;
    open = 1'b0;
    len_h = 16'h0000;
    type_h = 8'h00;
    ts_h = 32'h0;
    mismatches = 0;
  endfunction

  function void set_register(logic [fcb_pkg::CfgAddrW-1:0] addr, logic [16:0] data);
    if (addr == fcb_pkg::CfgBufferCapacity) begin
      capacity = data;
    end else if (addr == fcb_pkg::CfgMaxFrameType) begin
      max_type = data[7:0];
    end
  endfunction

  // CRC-8, MSB first, no reflection
  function logic [7:0] fold(logic [7:0] acc, logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ Poly) : (c << 1);
    return c;
  endfunction

  function logic [79:0] header_word();
    return {SyncHi, SyncLo, len_h, crc, type_h, ts_h};
  endfunction

  function void queue_header();
    logic [79:0] word;
    fcb_pkg::out_item_t res;
    word = header_word();
    for (int i = 0; i < HeaderLen; i++) begin
      res.header_index = 4'(i);
      res.header_byte = word[79-8*i -: 8];
      res.status = fcb_pkg::StatusOk;
      res.last = (i == HeaderLen - 1);
      expected_bytes.push_back(res);
    end
  endfunction

  function void take_request(fcb_pkg::in_item_t r);
    logic [79:0] word;
    fcb_pkg::out_item_t res;
    if (r.req_type == fcb_pkg::ReqOpen) begin
      if (r.frame_type > max_type || capacity < HeaderLen ||
          r.payload_length > capacity - HeaderLen) begin
        open = 1'b0;
        left = 16'h0000;
        res.header_index = 4'd0;
        res.header_byte = 8'h00;
        res.status = fcb_pkg::StatusReject;
        res.last = 1'b1;
        expected_bytes.push_back(res);
        return;
      end
      len_h = r.payload_length;
      type_h = r.frame_type;
      ts_h = r.timestamp;
      crc = 8'h00;
      word = header_word();
      // skip the CRC slot itself
      for (int i = 0; i < HeaderLen; i++) begin
        if (i != CrcPos) crc = fold(crc, word[79-8*i -: 8]);
      end
      left = r.payload_length;
      open = (r.payload_length != 16'h0000);
      if (!open) queue_header();
    end else if (open) begin
      crc = fold(crc, r.data_byte);
      left = left - 16'd1;
      if (left == 16'h0000) begin
        open = 1'b0;
        queue_header();
      end
    end
  endfunction

  function void match_result(fcb_pkg::out_item_t got);
    fcb_pkg::out_item_t want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: idx %0d byte %02h status %0b last %0b", $time,
               got.header_index, got.header_byte, got.status, got.last);
      return;
    end
    want = expected_bytes.pop_front();
    if (got.header_index !== want.header_index || got.header_byte !== want.header_byte ||
        got.status !== want.status || got.last !== want.last) begin
      mismatches++;
      $display("%0t: idx/byte/status/last expected %0d/%02h/%0b/%0b got %0d/%02h/%0b/%0b",
               $time, want.header_index, want.header_byte, want.status, want.last,
               got.header_index, got.header_byte, got.status, got.last);
    end
  endfunction
endclass

module framed_header_crc8_builder_test;
  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fcb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fcb_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [fcb_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [fcb_pkg::CfgDataW-1:0] cfg_wdata = '0;

  header_tracker tracker;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned counted = 0;
  int unsigned quiet = 0;
  bit stall_ask = 1'b0;

  framed_header_crc8_builder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Track accepted requests and results; end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_request(in_data);
      if (out_valid && out_ready) tracker.match_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_ask) begin
        stall_ask = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic fcb_pkg::in_item_t open_request(logic [15:0] len, logic [7:0] ftype,
                                                     logic [31:0] ts);
    fcb_pkg::in_item_t r;
    r.req_type = fcb_pkg::ReqOpen;
    r.payload_length = len;
    r.frame_type = ftype;
    r.timestamp = ts;
    r.data_byte = 8'($urandom);
    return r;
  endfunction

  function automatic fcb_pkg::in_item_t byte_request(logic [7:0] b);
    fcb_pkg::in_item_t r;
    r.req_type = fcb_pkg::ReqData;
    r.payload_length = 16'($urandom);
    r.frame_type = 8'($urandom);
    r.timestamp = $urandom;
    r.data_byte = b;
    return r;
  endfunction

  // Hold the request until it is taken.
  task automatic send_request(input fcb_pkg::in_item_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_register(input logic [fcb_pkg::CfgAddrW-1:0] addr,
                                input logic [16:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(addr, data);
  endtask

  // Let every expected result out, then allow payload-only requests to retire.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.expected_bytes.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic send_random_group();
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [7:0] ftype;
    pick = $urandom_range(99);
    ftype = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(tracker.max_type));
    if (pick < 70) begin
      // complete frame
      len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
      send_request(open_request(16'(len), ftype, $urandom));
      for (int i = 0; i < len; i++) send_request(byte_request(8'($urandom)));
      counted += len + 1;
    end else if (pick < 80) begin
      send_request(open_request(16'($urandom), 8'($urandom), $urandom));
      counted++;
    end else if (pick < 90) begin
      // stray payload bytes, mostly dropped by the block
      repeat ($urandom_range(3, 1)) send_request(byte_request(8'($urandom)));
    end else begin
      // truncated frame, left open until a later open or stray payload bytes
      len = $urandom_range(8, 2);
      cut = $urandom_range(len - 1);
      send_request(open_request(16'(len), ftype, $urandom));
      for (int i = 0; i < cut; i++) send_request(byte_request(8'($urandom)));
      counted += cut + 1;
    end
  endtask

  initial begin
    tracker = new();
    send_idle_pct = 12;
    recv_idle_pct = 83;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: capacity 1034, max type 3
    send_request(byte_request(8'h5A));
    send_request(open_request(16'd0, 8'd3, 32'hFFFF_FFFF));
    send_request(open_request(16'd0, 8'd4, 32'h0));
    send_request(open_request(16'd1024, 8'd0, 32'h0));
    send_request(open_request(16'd1025, 8'd0, 32'h0));
    send_request(byte_request(8'hFF));
    send_request(open_request(16'd2, 8'd1, 32'h1234_5678));
    send_request(byte_request(8'hFF));
    send_request(byte_request(8'h00));
    send_request(open_request(16'd3, 8'd2, 32'h8000_0001));
    send_request(byte_request(8'hA5));
    send_request(open_request(16'd1, 8'd3, 32'h0F0F_F0F0));
    send_request(byte_request(8'h3C));
    drain_results();

    write_register(fcb_pkg::CfgBufferCapacity, 17'd9);
    write_register(fcb_pkg::CfgMaxFrameType, 17'd255);
    send_request(open_request(16'd0, 8'd0, 32'h0));
    drain_results();

    write_register(fcb_pkg::CfgBufferCapacity, 17'd10);
    write_register(fcb_pkg::CfgMaxFrameType, 17'd0);
    send_request(open_request(16'd0, 8'd0, 32'hDEAD_BEEF));
    send_request(open_request(16'd1, 8'd0, 32'h0));
    send_request(open_request(16'd0, 8'd1, 32'h0));
    drain_results();

    write_register(fcb_pkg::CfgBufferCapacity, 17'd0);
    send_request(open_request(16'd0, 8'd0, 32'h0));
    drain_results();

    write_register(fcb_pkg::CfgBufferCapacity, 17'd65545);
    write_register(fcb_pkg::CfgMaxFrameType, 17'd255);
    send_request(open_request(16'hFFFF, 8'hFF, 32'h0));
    send_request(open_request(16'hFFFF, 8'hFF, 32'h5555_AAAA));
    send_request(open_request(16'd0, 8'hFF, 32'hAAAA_5555));
    send_request(byte_request(8'h81));

    counted = 0;
    while (counted < 120) send_random_group();
    drain_results();

    send_idle_pct = 83;
    recv_idle_pct = 12;
    write_register(fcb_pkg::CfgBufferCapacity, 17'd16);
    write_register(fcb_pkg::CfgMaxFrameType, 17'd7);
    counted = 0;
    while (counted < 120) send_random_group();
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(fcb_pkg::CfgBufferCapacity, 17'd1034);
    write_register(fcb_pkg::CfgMaxFrameType, 17'd3);
    // Hold the receiver while a burst of headers backs up into the input.
    stall_ask = 1'b1;
    counted = 0;
    repeat (8) begin
      send_request(open_request(16'd0, 8'($urandom_range(3)), $urandom));
      counted++;
    end
    while (counted < 110) send_random_group();
    drain_results();

    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
